// ===== design/addressed_frame_checksum_framer_defines.svh =====
`ifndef ADDRESSED_FRAME_CHECKSUM_FRAMER_DEFINES_SVH
`define ADDRESSED_FRAME_CHECKSUM_FRAMER_DEFINES_SVH

// Same-cycle check, off during reset.
`define AFCF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("afcf check failed");

// Next-cycle check, off during reset.
`define AFCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("afcf check failed");

// Next-cycle check that stays live through reset.
`define AFCF_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("afcf reset check failed");

`endif

// ===== design/afcf_pkg.sv =====
`timescale 1ns / 1ps

package afcf_pkg;

    localparam logic [7:0] MARK_START = 8'hFF;
    localparam logic [7:0] MARK_END   = 8'hFF;
    localparam logic [7:0] ESC_BYTE   = 8'hFE;
    localparam logic [7:0] ESC_FOR_FE = 8'h00;
    localparam logic [7:0] ESC_FOR_FF = 8'h01;
    localparam logic [7:0] SUM_IS_FE  = 8'hFE;
    localparam logic [7:0] SUM_IS_FF  = 8'hFF;

    localparam int APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_STATION_ADDRESS = 2'd0;

    // Command queue depth between front and back (at least 2).
    localparam int FIFO_DEPTH_DEF = 2;

    // One classified item: which parts of the line sequence it causes.
    typedef struct packed {
        logic       do_open;
        logic [7:0] addr;
        logic       data_en;
        logic [7:0] data;
        logic       do_close;
        logic [7:0] sum;
    } afcf_cmd_t;

endpackage

// ===== design/afcf_fifo.sv =====
`timescale 1ns / 1ps

module afcf_fifo #(
    parameter int DEPTH = afcf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  afcf_pkg::afcf_cmd_t   wr_data,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output afcf_pkg::afcf_cmd_t   rd_data
);
    import afcf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    afcf_cmd_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid & wr_ready;
    assign do_rd    = rd_valid & rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/afcf_front.sv =====
`timescale 1ns / 1ps

module afcf_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_payload_byte,
    input  logic                s_byte_present,
    input  logic                s_frame_first,
    input  logic                s_frame_last,
    input  logic [7:0]          station_address,
    output logic                push_valid,
    input  logic                push_ready,
    output afcf_pkg::afcf_cmd_t push_data
);
    import afcf_pkg::*;

    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       inside_reg;
    logic       inside_next;
    logic       in_frame;
    logic       data_en;
    logic       close_en;
    logic       accept;
    logic [7:0] seed;

    assign in_frame = s_frame_first | inside_reg;
    assign data_en  = s_byte_present & in_frame;
    assign close_en = s_frame_last & in_frame;
    assign seed     = s_frame_first ? station_address : sum_reg;
    assign sum_next = data_en ? seed + s_payload_byte : seed;
    assign inside_next = in_frame & ~close_en;

    // Drop items that put nothing on the line.
    assign s_ready    = push_ready;
    assign accept     = s_valid & push_ready;
    assign push_valid = s_valid & (s_frame_first | data_en | close_en);

    always_comb begin
        push_data          = '0;
        push_data.do_open  = s_frame_first;
        push_data.addr     = station_address;
        push_data.data_en  = data_en;
        push_data.data     = s_payload_byte;
        push_data.do_close = close_en;
        push_data.sum      = sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            inside_reg <= 1'b0;
        end else if (accept) begin
            sum_reg    <= sum_next;
            inside_reg <= inside_next;
        end
    end

endmodule

// ===== design/afcf_back.sv =====
`timescale 1ns / 1ps

module afcf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  afcf_pkg::afcf_cmd_t pop_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_line_byte,
    output logic                m_run_last,
    output logic                m_frame_end
);
    import afcf_pkg::*;

    typedef enum logic [2:0] {
        ST_START,
        ST_ADDR,
        ST_DATA,
        ST_SUM,
        ST_ESC,
        ST_END
    } step_t;

    step_t      step_reg;
    step_t      step_next;
    afcf_cmd_t  cur_reg;
    logic       cur_valid_reg;
    logic       m_valid_reg;
    logic [7:0] m_line_byte_reg;
    logic       m_run_last_reg;
    logic       m_frame_end_reg;

    logic [7:0] byte_c;
    logic       end_c;
    logic       last_c;
    logic       esc_c;
    logic       adv;
    logic       done_now;
    step_t      first_step;

    assign esc_c = (cur_reg.sum == SUM_IS_FE) | (cur_reg.sum == SUM_IS_FF);

    always_comb begin
        byte_c    = MARK_START;
        end_c     = 1'b0;
        last_c    = 1'b0;
        step_next = step_reg;
        unique case (step_reg)
            ST_START: begin
                byte_c    = MARK_START;
                step_next = ST_ADDR;
            end
            ST_ADDR: begin
                byte_c    = cur_reg.addr;
                last_c    = ~cur_reg.data_en & ~cur_reg.do_close;
                step_next = cur_reg.data_en ? ST_DATA : ST_SUM;
            end
            ST_DATA: begin
                byte_c    = cur_reg.data;
                last_c    = ~cur_reg.do_close;
                step_next = ST_SUM;
            end
            ST_SUM: begin
                byte_c    = esc_c ? ESC_BYTE : cur_reg.sum;
                step_next = esc_c ? ST_ESC : ST_END;
            end
            ST_ESC: begin
                byte_c    = (cur_reg.sum == SUM_IS_FE) ? ESC_FOR_FE : ESC_FOR_FF;
                step_next = ST_END;
            end
            ST_END: begin
                byte_c    = MARK_END;
                end_c     = 1'b1;
                last_c    = 1'b1;
                step_next = ST_END;
            end
            default: begin
                step_next = ST_START;
            end
        endcase
    end

    always_comb begin
        if (pop_data.do_open) begin
            first_step = ST_START;
        end else if (pop_data.data_en) begin
            first_step = ST_DATA;
        end else begin
            first_step = ST_SUM;
        end
    end

    assign adv       = cur_valid_reg & (~m_valid_reg | m_ready);
    assign done_now  = adv & last_c;
    assign pop_ready = ~cur_valid_reg | done_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= ST_START;
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (adv) begin
                m_valid_reg     <= 1'b1;
                m_line_byte_reg <= byte_c;
                m_run_last_reg  <= last_c;
                m_frame_end_reg <= end_c;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (pop_valid & pop_ready) begin
                cur_reg       <= pop_data;
                cur_valid_reg <= 1'b1;
                step_reg      <= first_step;
            end else if (done_now) begin
                cur_valid_reg <= 1'b0;
            end else if (adv) begin
                step_reg <= step_next;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_line_byte = m_line_byte_reg;
    assign m_run_last  = m_run_last_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule

// ===== design/addressed_frame_checksum_framer.sv =====
`timescale 1ns / 1ps
// Path: command queue, back end command register, output register. Throughput: one
// line byte per cycle while m_ready is high; an item holds the back end for all its
// line bytes (1 mid-frame, up to 6 for open+byte+escaped close); items that put out
// nothing never reach the back end; the FIFO_DEPTH command queue decouples both sides.
// Reset: aresetn synchronous, active low; clears sum, frame flag, queue, address.

module addressed_frame_checksum_framer #(
    parameter int FIFO_DEPTH = afcf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input item channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_payload_byte,
    input  logic                            s_byte_present,
    input  logic                            s_frame_first,
    input  logic                            s_frame_last,
    // line byte channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_line_byte,
    output logic                            m_run_last,
    output logic                            m_frame_end,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [afcf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import afcf_pkg::*;

    logic [7:0] station_address_reg;
    logic       cfg_wr;

    logic       push_valid;
    logic       push_ready;
    afcf_cmd_t  push_data;
    logic       pop_valid;
    logic       pop_ready;
    afcf_cmd_t  pop_data;

    // ------------------------------------------------------------------
    // Register port: zero wait states, station address at offset 0.
    // The address is sampled by the front end when a frame opens, so a
    // write between frames takes effect on the next open.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr == ADDR_STATION_ADDRESS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_address_reg <= '0;
        end else if (cfg_wr) begin
            station_address_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_STATION_ADDRESS) begin
            prdata = {24'b0, station_address_reg};
        end
    end

    // ------------------------------------------------------------------
    // Front end: take one item per cycle while push_ready, advance the
    // running sum and the frame flag, and turn the item into a command
    // naming its line bytes (start+address, payload, checksum+end).
    // ------------------------------------------------------------------
    afcf_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload_byte  (s_payload_byte),
        .s_byte_present  (s_byte_present),
        .s_frame_first   (s_frame_first),
        .s_frame_last    (s_frame_last),
        .station_address (station_address_reg),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    // ------------------------------------------------------------------
    // Command queue: lets the front keep taking items while the back
    // end is busy with the line bytes of a frame open or close.
    // ------------------------------------------------------------------
    afcf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    // ------------------------------------------------------------------
    // Back end: walk each command one line byte per cycle while
    // m_ready allows, escape the checksum, flag the item's last byte
    // and the closing marker, and hold the byte in the output register.
    // ------------------------------------------------------------------
    afcf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_line_byte (m_line_byte),
        .m_run_last  (m_run_last),
        .m_frame_end (m_frame_end)
    );

endmodule

// ===== design/afcf_checker.sv =====
`timescale 1ns / 1ps
`include "addressed_frame_checksum_framer_defines.svh"

module afcf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_line_byte,
    input logic       m_run_last,
    input logic       m_frame_end
);
    import afcf_pkg::*;

    // Closing marker is 0xFF and always ends the item's run.
    `AFCF_ASSERT_NOW(a_end_marker, m_valid && m_frame_end, m_run_last && (m_line_byte == MARK_END))

    // Stalled result holds.
    `AFCF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid)
    `AFCF_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_line_byte))

    // Reset empties the block and opens the input.
    `AFCF_ASSERT_RST(a_reset_empty, !aresetn, !m_valid && s_ready)

endmodule

bind addressed_frame_checksum_framer afcf_checker u_afcf_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// One line byte as it shows on the result channel.
typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_end;
} line_byte_t;

// Predicts the line bytes for each accepted item and checks them in order.
class framer_scoreboard;
    logic [7:0] station_addr;
    logic [7:0] running_sum;
    logic       in_frame;
    line_byte_t bytes_due[$];
    int         fails;

    function new();
        station_addr = 8'h00;
        running_sum  = 8'h00;
        in_frame     = 1'b0;
        fails        = 0;
    endfunction

    // Returns how many line bytes the item causes.
    function int note_item(logic [7:0] data, logic present, logic first, logic last);
        line_byte_t fresh[6];
        int         n;
        n = 0;
        if (first) begin
            fresh[n++] = {afcf_pkg::MARK_START, 1'b0, 1'b0};
            fresh[n++] = {station_addr, 1'b0, 1'b0};
            running_sum = station_addr;
            in_frame    = 1'b1;
        end
        if (present && in_frame) begin
            fresh[n++] = {data, 1'b0, 1'b0};
            running_sum = running_sum + data;
        end
        if (last && in_frame) begin
            if (running_sum == afcf_pkg::SUM_IS_FE) begin
                fresh[n++] = {afcf_pkg::ESC_BYTE, 1'b0, 1'b0};
                fresh[n++] = {afcf_pkg::ESC_FOR_FE, 1'b0, 1'b0};
            end else if (running_sum == afcf_pkg::SUM_IS_FF) begin
                fresh[n++] = {afcf_pkg::ESC_BYTE, 1'b0, 1'b0};
                fresh[n++] = {afcf_pkg::ESC_FOR_FF, 1'b0, 1'b0};
            end else begin
                fresh[n++] = {running_sum, 1'b0, 1'b0};
            end
            fresh[n++] = {afcf_pkg::MARK_END, 1'b0, 1'b1};
            in_frame = 1'b0;
        end
        if (n > 0) fresh[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++) bytes_due.push_back(fresh[i]);
        return n;
    endfunction

    function void check_line_byte(line_byte_t got);
        line_byte_t want;
        if (bytes_due.size() == 0) begin
            $error("line byte %h with nothing expected", got.line_byte);
            fails++;
            return;
        end
        want = bytes_due.pop_front();
        if (got.line_byte !== want.line_byte) begin
            $error("line_byte expected %h actual %h", want.line_byte, got.line_byte);
            fails++;
        end
        if (got.run_last !== want.run_last) begin
            $error("run_last expected %b actual %b", want.run_last, got.run_last);
            fails++;
        end
        if (got.frame_end !== want.frame_end) begin
            $error("frame_end expected %b actual %b", want.frame_end, got.frame_end);
            fails++;
        end
    endfunction
endclass

module testbench;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PER_PHASE = 78;

    logic                            aclk           = 1'b0;
    logic                            aresetn        = 1'b0;
    logic                            s_valid        = 1'b0;
    logic                            s_ready;
    logic [7:0]                      s_payload_byte = 8'h00;
    logic                            s_byte_present = 1'b0;
    logic                            s_frame_first  = 1'b0;
    logic                            s_frame_last   = 1'b0;
    logic                            m_valid;
    logic                            m_ready        = 1'b0;
    logic [7:0]                      m_line_byte;
    logic                            m_run_last;
    logic                            m_frame_end;
    logic                            psel           = 1'b0;
    logic                            penable        = 1'b0;
    logic                            pwrite         = 1'b0;
    logic [afcf_pkg::APB_ADDR_W-1:0] paddr          = '0;
    logic [31:0]                     pwdata         = 32'h0;
    logic [31:0]                     prdata;
    logic                            pready;

    framer_scoreboard sb;
    bit               quiet = 1'b0;   // no idling on either side while set
    int               items_effective = 0;
    int               stall_left = 0;
    int               idle_cycles = 0;

    addressed_frame_checksum_framer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_byte_present (s_byte_present),
        .s_frame_first  (s_frame_first),
        .s_frame_last   (s_frame_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_byte    (m_line_byte),
        .m_run_last     (m_run_last),
        .m_frame_end    (m_frame_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Pick an idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: check every accepted line byte, stall ready at random.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_line_byte({m_line_byte, m_run_last, m_frame_end});
            if (stall_left > 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item, hold it until accepted, then hand it to the predictor.
    task automatic send_item(logic [7:0] data, logic present, logic first, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_payload_byte <= data;
        s_byte_present <= present;
        s_frame_first  <= first;
        s_frame_last   <= last;
        do @(posedge aclk); while (!s_ready);
        if (sb.note_item(data, present, first, last) > 0) items_effective++;
    endtask

    // Drop valid, wait for every expected byte, then let the pipeline drain.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.bytes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register access: setup phase, then access phase until pready.
    task automatic apb_access(logic wr, logic [afcf_pkg::APB_ADDR_W-1:0] addr,
                              logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the station address, mirror it in the predictor, read it back.
    task automatic set_station_address(logic [7:0] addr);
        logic [31:0] rd;
        settle();
        apb_access(1'b1, afcf_pkg::ADDR_STATION_ADDRESS, {24'h0, addr}, rd);
        sb.station_addr = addr;
        @(posedge aclk);
        apb_access(1'b0, afcf_pkg::ADDR_STATION_ADDRESS, 32'h0, rd);
        if (rd !== {24'h0, addr}) begin
            $error("station_address expected %h actual %h", {24'h0, addr}, rd);
            sb.fails++;
        end
    endtask

    // One well-formed frame with random content; now and then left unclosed.
    // Steer some closing bytes so the sum lands on a value that needs escaping.
    task automatic random_frame();
        int          len;
        bit          unclosed;
        logic [31:0] rnd;
        logic [7:0]  data;
        logic [7:0]  base;
        logic        present;
        logic        last;
        len      = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 20);
        unclosed = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
            rnd     = $urandom;
            data    = rnd[7:0];
            last    = (i == len - 1) && !unclosed;
            present = (len == 1) ? rnd[8] : ($urandom_range(0, 9) != 0);
            if (last && present && $urandom_range(0, 3) == 0) begin
                base = (i == 0) ? sb.station_addr : sb.running_sum;
                data = (rnd[9] ? afcf_pkg::SUM_IS_FE : afcf_pkg::SUM_IS_FF) - base;
            end
            send_item(data, present, i == 0, last);
        end
    endtask

    // Mostly frames; the rest is noise with every field random.
    task automatic random_phase(int target);
        int          start;
        logic [31:0] rnd;
        start = items_effective;
        while (items_effective - start < target) begin
            if ($urandom_range(0, 99) < 80) begin
                random_frame();
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    rnd = $urandom;
                    send_item(rnd[7:0], rnd[8], rnd[9], rnd[10]);
                end
            end
        end
    endtask

    initial begin
        logic [31:0] rnd;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Address from reset (zero): empty frame, stray byte, stray close,
        // escaped sums, a six-byte item and a reopen inside a frame.
        send_item(8'h00, 1'b0, 1'b1, 1'b1);
        send_item(8'h55, 1'b1, 1'b0, 1'b0);
        send_item(8'hAA, 1'b0, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1, 1'b1);
        send_item(8'h12, 1'b1, 1'b1, 1'b0);
        send_item(8'h34, 1'b0, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0, 1'b1);

        // Top address: empty frame escapes the sum, a wrap brings it to zero.
        set_station_address(8'hFF);
        send_item(8'h00, 1'b0, 1'b1, 1'b1);
        send_item(8'h01, 1'b1, 1'b1, 1'b1);

        set_station_address(8'hFE);
        send_item(8'h00, 1'b0, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0, 1'b1);

        // Random phases under several addresses, one of them with no idling.
        set_station_address(8'h00);
        random_phase(RANDOM_PER_PHASE);
        rnd = $urandom;
        set_station_address(rnd[7:0]);
        quiet = 1'b1;
        random_phase(RANDOM_PER_PHASE);
        quiet = 1'b0;
        set_station_address(8'hFF);
        random_phase(RANDOM_PER_PHASE);
        rnd = $urandom;
        set_station_address(rnd[7:0]);
        random_phase(RANDOM_PER_PHASE);

        settle();
        if (sb.fails == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== addressed_frame_checksum_framer.f =====
+incdir+design
design/afcf_pkg.sv
design/afcf_fifo.sv
design/afcf_front.sv
design/afcf_back.sv
design/addressed_frame_checksum_framer.sv
design/afcf_checker.sv
bench/testbench.sv
